// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, byte codes and command word table for the sentence parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int STORE_BYTES_DEF     = 64;
  localparam int MAX_FIELD_BYTES_DEF = 15;

  localparam int PREFIX_LEN = 6;
  localparam int CODE_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int LEN_W      = 6;
  localparam int NUM_WORDS  = 9;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [CODE_W-1:0] {
    CMD_UNKNOWN   = 4'd0,
    CMD_ENABLE    = 4'd1,
    CMD_PING      = 4'd2,
    CMD_RESET     = 4'd3,
    CMD_RELEASE   = 4'd4,
    CMD_TXPOWER   = 4'd5,
    CMD_RXSENSE   = 4'd6,
    CMD_GETSTATUS = 4'd7,
    CMD_GETTIME   = 4'd8,
    CMD_SETTIME   = 4'd9
  } cmd_code_t;

  // conversion of the first field: blanks, then sign or digits, then done
  typedef enum logic [2:0] {
    PH_BLANKS = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } conv_phase_t;

  // byte 0 sits in the top bits, so a string literal compares directly
  typedef logic [0:PREFIX_LEN-1][7:0] prefix_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
  } result_t;

  localparam logic [8*PREFIX_LEN-1:0] CMD_WORDS [NUM_WORDS] = '{
    "$PSENA", "$PSPNG", "$PSRST", "$PSREL", "$PSTXP",
    "$PSRXS", "$PGSTA", "$PGTIM", "$PSTIM"
  };

  localparam cmd_code_t CMD_OF_WORD [NUM_WORDS] = '{
    CMD_ENABLE, CMD_PING, CMD_RESET, CMD_RELEASE, CMD_TXPOWER,
    CMD_RXSENSE, CMD_GETSTATUS, CMD_GETTIME, CMD_SETTIME
  };

  function automatic cmd_code_t match_command(input prefix_t p);
    cmd_code_t code;
    code = CMD_UNKNOWN;
    // scan from the back so the first matching word wins
    for (int k = NUM_WORDS - 1; k >= 0; k--) begin
      if (p == CMD_WORDS[k]) code = CMD_OF_WORD[k];
    end
    return code;
  endfunction

endpackage

// ===== rtl/scp_rx_if.sv =====
// ----------------------------------------------------------------------------
// scp_rx_if
// Byte channel into the sentence parser: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface scp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/scp_res_if.sv =====
// ----------------------------------------------------------------------------
// scp_res_if
// Result channel of the sentence parser: command code, parameter, length.
// ----------------------------------------------------------------------------
interface scp_res_if;
  logic                        valid;
  logic                        ready;
  logic [scp_pkg::CODE_W-1:0]  command_code;
  logic [scp_pkg::VALUE_W-1:0] parameter_value;
  logic [scp_pkg::LEN_W-1:0]   sentence_length;

  modport source (output valid, output command_code, output parameter_value,
                  output sentence_length, input ready);
  modport sink   (input valid, input command_code, input parameter_value,
                  input sentence_length, output ready);
endinterface

// ===== rtl/sentence_command_parser.sv =====
// ----------------------------------------------------------------------------
// sentence_command_parser
// Decodes "$XXXXX,<number>,...<CR><LF>" command sentences byte by byte.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | words
//  --------+-----+--------------------------------------------------+-------------
//  rx      | in  | rx_byte[7:0]                                     | 1 per cycle while ready
//  res     | out | command_code[3:0] parameter_value[31:0]          | 1 per CR LF
//          |     | sentence_length[5:0]                             |
//
//  One byte is taken every cycle while rx.ready is high; all parsing state updates in that cycle.
//  A result is registered after its LF byte, into the output register or, if that holds an unread word, the skid stage.
//  The output register has a one-word skid stage behind it; rx.ready drops
//  only while the skid stage holds a word, i.e. after two unread results.
//  Synchronous active-high reset clears all parsing state and the valid flags of both stages.
// ----------------------------------------------------------------------------
module sentence_command_parser #(
  parameter int STORE_BYTES     = scp_pkg::STORE_BYTES_DEF,
  parameter int MAX_FIELD_BYTES = scp_pkg::MAX_FIELD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  scp_rx_if.sink     rx,
  scp_res_if.source  res
);

  localparam int PW = $clog2(STORE_BYTES);
  localparam int FW = PW + 1;
  localparam int DW = PW + 2;
  localparam int LW = scp_pkg::LEN_W;
  localparam int VW = scp_pkg::VALUE_W;

  // parsing state
  logic                         in_sentence, in_sentence_next;
  logic [7:0]                   previous_byte;
  logic [PW-1:0]                byte_position, byte_position_next;
  logic [1:0]                   comma_count, comma_count_next;
  logic [FW-1:0]                first_field_start, first_field_start_next;
  scp_pkg::prefix_t             prefix_bytes, prefix_bytes_next;
  logic [scp_pkg::VALUE_W-1:0]  number_accumulator, number_accumulator_next;
  scp_pkg::conv_phase_t         conversion_phase, conversion_phase_next;
  logic                         negative_sign, negative_sign_next;
  logic [scp_pkg::VALUE_W-1:0]  held_parameter, held_parameter_next;

  // output stages
  logic                         out_valid, skid_valid;
  scp_pkg::result_t             out_word, skid_word, new_word;

  logic                         take, result_fire;
  logic [7:0]                   b;
  logic                         is_digit, is_blank, is_sign;
  logic [PW-1:0]                pos_inc;
  logic [DW-1:0]                field_len;
  logic                         field_ok;
  logic [scp_pkg::VALUE_W-1:0]  acc_times_ten;

  assign b    = rx.rx_byte;
  assign take = rx.valid && rx.ready;
  assign rx.ready = !skid_valid;

  assign is_digit = (b >= scp_pkg::CH_ZERO) && (b <= scp_pkg::CH_NINE);
  assign is_blank = (b == scp_pkg::CH_SPACE) ||
                    ((b >= scp_pkg::CH_TAB) && (b <= scp_pkg::CH_CR));
  assign is_sign  = (b == scp_pkg::CH_PLUS) || (b == scp_pkg::CH_MINUS);

  assign acc_times_ten = (number_accumulator << 3) + (number_accumulator << 1);

  assign pos_inc = (byte_position == PW'(STORE_BYTES - 1)) ? '0
                                                           : byte_position + PW'(1);

  // length from after the first comma up to this comma, signed
  assign field_len = {2'b00, byte_position} - {1'b0, first_field_start};
  assign field_ok  = !field_len[DW-1] && (field_len != '0) &&
                     (field_len <= DW'(MAX_FIELD_BYTES));

  assign result_fire = take && (b != scp_pkg::CH_START) && in_sentence &&
                       (b == scp_pkg::CH_LF) && (previous_byte == scp_pkg::CH_CR);

  always_comb begin
    in_sentence_next        = in_sentence;
    byte_position_next      = byte_position;
    comma_count_next        = comma_count;
    first_field_start_next  = first_field_start;
    prefix_bytes_next       = prefix_bytes;
    number_accumulator_next = number_accumulator;
    conversion_phase_next   = conversion_phase;
    negative_sign_next      = negative_sign;
    held_parameter_next     = held_parameter;

    if (b == scp_pkg::CH_START) begin
      prefix_bytes_next[0]    = scp_pkg::CH_START;
      in_sentence_next        = 1'b1;
      byte_position_next      = PW'(1);
      comma_count_next        = 2'd0;
      number_accumulator_next = '0;
      conversion_phase_next   = scp_pkg::PH_BLANKS;
      negative_sign_next      = 1'b0;
    end else if (in_sentence) begin
      for (int i = 0; i < scp_pkg::PREFIX_LEN; i++) begin
        if (byte_position == PW'(i)) prefix_bytes_next[i] = b;
      end

      if (b == scp_pkg::CH_COMMA && comma_count == 2'd0) begin
        first_field_start_next  = {1'b0, byte_position} + FW'(1);
        comma_count_next        = 2'd1;
        number_accumulator_next = '0;
        conversion_phase_next   = scp_pkg::PH_BLANKS;
        negative_sign_next      = 1'b0;
      end else if (b == scp_pkg::CH_COMMA && comma_count == 2'd1) begin
        comma_count_next = 2'd2;
        if (field_ok) begin
          held_parameter_next = negative_sign ? (~number_accumulator + VW'(1))
                                              : number_accumulator;
        end
      end else if (comma_count == 2'd1) begin
        case (conversion_phase)
          scp_pkg::PH_BLANKS: begin
            if (is_blank) begin
              conversion_phase_next = scp_pkg::PH_BLANKS;
            end else if (is_sign) begin
              negative_sign_next    = (b == scp_pkg::CH_MINUS);
              conversion_phase_next = scp_pkg::PH_DIGITS;
            end else if (is_digit) begin
              conversion_phase_next   = scp_pkg::PH_DIGITS;
              number_accumulator_next = acc_times_ten +
                                        {{(scp_pkg::VALUE_W-4){1'b0}}, b[3:0]};
            end else begin
              conversion_phase_next = scp_pkg::PH_DONE;
            end
          end
          scp_pkg::PH_DIGITS: begin
            if (is_digit) begin
              number_accumulator_next = acc_times_ten +
                                        {{(scp_pkg::VALUE_W-4){1'b0}}, b[3:0]};
            end else begin
              conversion_phase_next = scp_pkg::PH_DONE;
            end
          end
          default: begin
            conversion_phase_next = conversion_phase;
          end
        endcase
      end

      if (b == scp_pkg::CH_LF && previous_byte == scp_pkg::CH_CR) begin
        // mark the byte after the terminator so short sentences never match
        for (int i = 0; i < scp_pkg::PREFIX_LEN; i++) begin
          if ({1'b0, byte_position} + FW'(1) == FW'(i)) prefix_bytes_next[i] = 8'h00;
        end
        in_sentence_next = 1'b0;
      end else begin
        byte_position_next = pos_inc;
      end
    end
  end

  always_comb begin
    new_word.code   = scp_pkg::match_command(prefix_bytes_next);
    new_word.value  = held_parameter_next;
    new_word.length = LW'(byte_position);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence        <= 1'b0;
      previous_byte      <= 8'h00;
      byte_position      <= '0;
      comma_count        <= 2'd0;
      first_field_start  <= '0;
      prefix_bytes       <= '0;
      number_accumulator <= '0;
      conversion_phase   <= scp_pkg::PH_BLANKS;
      negative_sign      <= 1'b0;
      held_parameter     <= '0;
    end else if (take) begin
      in_sentence        <= in_sentence_next;
      previous_byte      <= b;
      byte_position      <= byte_position_next;
      comma_count        <= comma_count_next;
      first_field_start  <= first_field_start_next;
      prefix_bytes       <= prefix_bytes_next;
      number_accumulator <= number_accumulator_next;
      conversion_phase   <= conversion_phase_next;
      negative_sign      <= negative_sign_next;
      held_parameter     <= held_parameter_next;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result_fire) begin
      if (!out_valid || res.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && res.ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      if (!out_valid || res.ready) begin
        out_word <= new_word;
      end else begin
        skid_word <= new_word;
      end
    end else if (out_valid && res.ready && skid_valid) begin
      out_word <= skid_word;
    end
  end

  assign res.valid           = out_valid;
  assign res.command_code    = out_word.code;
  assign res.parameter_value = out_word.value;
  assign res.sentence_length = out_word.length;

endmodule
